[rtl/core/aeq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aeq_pkg
// Shared types, widths and the microcode table of the allpass peaking equalizer.
// ----------------------------------------------------------------------------
package aeq_pkg;

	// fixed field widths
	localparam int COEF_W    = 24;
	localparam int GAIN_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int DLY_W     = 32;

	// datapath widths
	localparam int K_W   = 27;
	localparam int MA_W  = 27;
	localparam int MB_W  = 33;
	localparam int P_W   = MA_W + MB_W;
	localparam int ACC_W = 64;
	localparam int WS_W  = 43;
	localparam int DIF_W = 39;
	localparam int LO_W  = 16;

	localparam int COEF_FRAC = 22;
	localparam int GAIN_FRAC = 16;

	// reset values of the coefficient registers
	localparam logic signed [COEF_W-1:0] CENTER_RST = 24'sd0;
	localparam logic signed [COEF_W-1:0] BW_RST     = 24'sd4194304;
	localparam logic [GAIN_W-1:0]        GAIN_RST   = 24'd65536;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BW     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

	// microprogram
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;

	typedef enum logic [2:0] {
		MS_D_AP = 3'd0,
		MS_K_Z1 = 3'd1,
		MS_A_Z2 = 3'd2,
		MS_A_W  = 3'd3,
		MS_G_LO = 3'd4,
		MS_G_HI = 3'd5
	} msel_t;

	typedef enum logic [2:0] {
		AOP_NOP      = 3'd0,
		AOP_LOAD_R22 = 3'd1,
		AOP_SUB      = 3'd2,
		AOP_ADD      = 3'd3,
		AOP_ADD_SH16 = 3'd4,
		AOP_LOAD_S   = 3'd5
	} aop_t;

	typedef enum logic [2:0] {
		DST_NONE = 3'd0,
		DST_K    = 3'd1,
		DST_W    = 3'd2,
		DST_Y    = 3'd3,
		DST_O    = 3'd4
	} dst_t;

	typedef enum logic [1:0] {
		JMP_NEXT     = 2'd0,
		JMP_WAIT_IN  = 2'd1,
		JMP_WAIT_OUT = 2'd2
	} jmp_t;

	typedef struct packed {
		msel_t msel;
		aop_t  aop;
		dst_t  dst;
		jmp_t  jmp;
	} uword_t;

	typedef struct packed {
		msel_t msel;
		aop_t  aop;
		dst_t  dst;
		logic  take_in;
	} ctrl_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] center;
		logic signed [COEF_W-1:0] bandwidth;
		logic [GAIN_W-1:0]        gain;
	} coef_t;

	// the product issued in one step is accumulated in the next
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t uw;
		case (step)
			4'd0:  uw = '{MS_D_AP, AOP_NOP,      DST_NONE, JMP_WAIT_IN};
			4'd1:  uw = '{MS_D_AP, AOP_LOAD_R22, DST_NONE, JMP_NEXT};
			4'd2:  uw = '{MS_D_AP, AOP_NOP,      DST_K,    JMP_NEXT};
			4'd3:  uw = '{MS_K_Z1, AOP_NOP,      DST_NONE, JMP_NEXT};
			4'd4:  uw = '{MS_A_Z2, AOP_LOAD_R22, DST_NONE, JMP_NEXT};
			4'd5:  uw = '{MS_D_AP, AOP_SUB,      DST_NONE, JMP_NEXT};
			4'd6:  uw = '{MS_D_AP, AOP_NOP,      DST_W,    JMP_NEXT};
			4'd7:  uw = '{MS_A_W,  AOP_NOP,      DST_NONE, JMP_NEXT};
			4'd8:  uw = '{MS_K_Z1, AOP_LOAD_R22, DST_NONE, JMP_NEXT};
			4'd9:  uw = '{MS_D_AP, AOP_SUB,      DST_NONE, JMP_NEXT};
			4'd10: uw = '{MS_D_AP, AOP_NOP,      DST_Y,    JMP_NEXT};
			4'd11: uw = '{MS_G_LO, AOP_LOAD_S,   DST_NONE, JMP_NEXT};
			4'd12: uw = '{MS_G_HI, AOP_ADD,      DST_NONE, JMP_NEXT};
			4'd13: uw = '{MS_D_AP, AOP_ADD_SH16, DST_NONE, JMP_NEXT};
			4'd14: uw = '{MS_D_AP, AOP_NOP,      DST_O,    JMP_WAIT_OUT};
			default: uw = '{MS_D_AP, AOP_NOP,    DST_NONE, JMP_WAIT_OUT};
		endcase
		return uw;
	endfunction

endpackage
`default_nettype wire

[rtl/core/aeq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aeq_if
// Request channels of the equalizer: sample in, sample out and register write.
// ----------------------------------------------------------------------------
interface aeq_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface aeq_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface aeq_cfg_if ();
	logic                            valid;
	logic                            ready;
	logic [aeq_pkg::CFG_IDX_W-1:0]   index;
	logic [aeq_pkg::COEF_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/aeq_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aeq_cfg_regs
// Coefficient registers: center, bandwidth and gain, written by index.
// ----------------------------------------------------------------------------
module aeq_cfg_regs (
	input  wire            clk,
	input  wire            arst_n,
	aeq_cfg_if.sink        cfg,
	output aeq_pkg::coef_t coef
);
	import aeq_pkg::*;

	coef_t coef_q;

	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	// unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.center    <= CENTER_RST;
			coef_q.bandwidth <= BW_RST;
			coef_q.gain      <= GAIN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER: coef_q.center    <= signed'(cfg.data);
				REG_BW:     coef_q.bandwidth <= signed'(cfg.data);
				REG_GAIN:   coef_q.gain      <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/aeq_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aeq_sequencer
// Step counter over the microcode table, with waits on the input and output.
// ----------------------------------------------------------------------------
module aeq_sequencer (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire            out_busy,
	output logic           in_ready,
	output aeq_pkg::ctrl_t ctrl
);
	import aeq_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	uword_t            uw;
	logic              in_fire;

	assign uw       = ucode_rom(step_q);
	assign in_ready = (uw.jmp == JMP_WAIT_IN);
	assign in_fire  = in_ready && in_valid;

	always_comb begin
		ctrl.msel    = uw.msel;
		ctrl.aop     = uw.aop;
		ctrl.take_in = in_fire;
		// result write holds off while the output register is still full
		if (uw.dst == DST_O && out_busy) begin
			ctrl.dst = DST_NONE;
		end else begin
			ctrl.dst = uw.dst;
		end
	end

	always_comb begin
		case (uw.jmp)
			JMP_NEXT:     step_nxt = step_q + 1'b1;
			JMP_WAIT_IN:  step_nxt = in_fire ? step_q + 1'b1 : step_q;
			JMP_WAIT_OUT: step_nxt = out_busy ? step_q : STEP_IDLE;
			default:      step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule
`default_nettype wire

[rtl/core/aeq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aeq_datapath
// Shared multiplier, accumulator, delay registers and output register.
// ----------------------------------------------------------------------------
module aeq_datapath #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  aeq_pkg::ctrl_t                ctrl,
	input  aeq_pkg::coef_t                coef,
	input  wire signed [SAMPLE_BITS-1:0]  x_in,
	input  wire                           out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] out_data,
	output logic                          out_busy
);
	import aeq_pkg::*;

	localparam logic signed [ACC_W-1:0] RND22 = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
	localparam logic signed [ACC_W-1:0] RND17 = ACC_W'(64'sd1 <<< GAIN_FRAC);
	localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
	localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] O_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] O_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [K_W-1:0]         k_q;
	logic signed [DLY_W-1:0]       w_q;
	logic signed [DLY_W-1:0]       z1_q;
	logic signed [DLY_W-1:0]       z2_q;
	logic signed [DIF_W-1:0]       s_q;
	logic signed [DIF_W-1:0]       dif_q;
	logic signed [P_W-1:0]         prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	logic signed [MA_W-1:0]        ma;
	logic signed [MB_W-1:0]        mb;
	logic signed [COEF_W:0]        a_plus;
	logic signed [ACC_W-1:0]       prod_ext;
	logic signed [ACC_W-1:0]       acc_nxt;
	logic signed [ACC_W-1:0]       sh22;
	logic signed [ACC_W-1:0]       sh17;
	logic signed [WS_W-1:0]        wsum;
	logic signed [DLY_W-1:0]       w_sat;
	logic [WS_W-DLY_W:0]           w_hi;
	logic signed [DIF_W-1:0]       ysum;
	logic [ACC_W-SAMPLE_BITS:0]    o_hi;
	logic signed [SAMPLE_BITS-1:0] o_sat;
	logic                          commit;

	// 1 + a in Q2.22
	assign a_plus = (COEF_W+1)'(coef.bandwidth) + (COEF_W+1)'(1 <<< COEF_FRAC);

	always_comb begin
		case (ctrl.msel)
			MS_D_AP: begin
				ma = MA_W'(coef.center);
				mb = MB_W'(a_plus);
			end
			MS_K_Z1: begin
				ma = k_q;
				mb = MB_W'(z1_q);
			end
			MS_A_Z2: begin
				ma = MA_W'(coef.bandwidth);
				mb = MB_W'(z2_q);
			end
			MS_A_W: begin
				ma = MA_W'(coef.bandwidth);
				mb = MB_W'(w_q);
			end
			// gain times difference, split into a low unsigned and a high signed part
			MS_G_LO: begin
				ma = MA_W'({1'b0, coef.gain});
				mb = MB_W'({1'b0, dif_q[LO_W-1:0]});
			end
			MS_G_HI: begin
				ma = MA_W'({1'b0, coef.gain});
				mb = MB_W'(signed'(dif_q[DIF_W-1:LO_W]));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);

	always_comb begin
		case (ctrl.aop)
			AOP_NOP:      acc_nxt = acc_q;
			AOP_LOAD_R22: acc_nxt = prod_ext + RND22;
			AOP_SUB:      acc_nxt = acc_q - prod_ext;
			AOP_ADD:      acc_nxt = acc_q + prod_ext;
			AOP_ADD_SH16: acc_nxt = acc_q + (prod_ext <<< LO_W);
			AOP_LOAD_S:   acc_nxt = (ACC_W'(s_q) <<< GAIN_FRAC) + RND17;
			default:      acc_nxt = acc_q;
		endcase
	end

	// rounding bias is already in the accumulator, so a shift finishes it
	assign sh22 = acc_q >>> COEF_FRAC;
	assign sh17 = acc_q >>> (GAIN_FRAC + 1);

	assign wsum  = WS_W'(signed'(sh22[WS_W-2:0])) + WS_W'(x_q);
	assign w_hi  = wsum[WS_W-1:DLY_W-1];
	assign w_sat = ((&w_hi) || !(|w_hi)) ? wsum[DLY_W-1:0] : (wsum[WS_W-1] ? DLY_MIN : DLY_MAX);

	assign ysum = signed'(sh22[DIF_W-1:0]) + DIF_W'(z2_q);

	assign o_hi  = sh17[ACC_W-1:SAMPLE_BITS-1];
	assign o_sat = ((&o_hi) || !(|o_hi)) ? sh17[SAMPLE_BITS-1:0] :
		(sh17[ACC_W-1] ? O_MIN : O_MAX);

	assign commit    = (ctrl.dst == DST_O);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		acc_q  <= acc_nxt;
		if (ctrl.take_in) begin
			x_q <= x_in;
		end
		case (ctrl.dst)
			DST_K: k_q <= sh22[K_W-1:0];
			DST_W: w_q <= w_sat;
			DST_Y: begin
				s_q   <= DIF_W'(x_q) + ysum;
				dif_q <= DIF_W'(x_q) - ysum;
			end
			DST_O: out_q <= o_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q        <= '0;
			z2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				z2_q        <= z1_q;
				z1_q        <= w_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/allpass_peaking_equalizer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// allpass_peaking_equalizer_top
// Second-order allpass lattice peaking equalizer on a microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   din  carries one signed audio sample per request; dout returns one
//   equalized, saturated sample per input sample, in order.
//   cfg writes the coefficients: index 0 center (d), 1 bandwidth (a),
//   2 gain (g); other indexes are ignored. cfg is always ready; write it
//   only while no sample is in flight.
//   A sample is taken in the idle step; its result is loaded into the output
//   register at the last step of the 15-step microprogram, which runs all
//   seven products through one shared 27x33 multiplier.
//   The output register lets the next sample start while a result waits.
//   If the receiver stalls, the program holds at its last step until the
//   output register frees, and din is not ready until then.
//   Reset loads the default coefficients (d = 0, a = 1.0, g = 1.0), clears
//   both delays and empties the output register; no clearing pass follows.
// ----------------------------------------------------------------------------
module allpass_peaking_equalizer_top #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire       clk,
	input  wire       arst_n,
	aeq_in_if.sink    din,
	aeq_out_if.source dout,
	aeq_cfg_if.sink   cfg
);
	import aeq_pkg::*;

	coef_t                         coef;
	ctrl_t                         ctrl;
	logic                          out_busy;
	logic                          out_valid;
	logic signed [SAMPLE_BITS-1:0] out_data;

	aeq_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	aeq_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.out_busy (out_busy),
		.in_ready (din.ready),
		.ctrl     (ctrl)
	);

	aeq_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.coef      (coef),
		.x_in      (din.sample_in),
		.out_ready (dout.ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_busy  (out_busy)
	);

	assign dout.valid      = out_valid;
	assign dout.sample_out = out_data;

endmodule
`default_nettype wire
